### rtl/core/bpa_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bpa_pkg
// Shared widths and codes for the bitmap page allocator.
// ----------------------------------------------------------------------------
package bpa_pkg;

    localparam int unsigned WORD_BITS   = 32;
    localparam int unsigned BIT_SEL_W   = 5;
    localparam int unsigned INDEX_W     = 12;
    localparam int unsigned COUNT_W     = 13;

    localparam logic CMD_ALLOC = 1'b0;
    localparam logic CMD_FREE  = 1'b1;

    localparam logic STATUS_DONE     = 1'b0;
    localparam logic STATUS_NO_SPACE = 1'b1;

endpackage

### rtl/core/bitmap_page_allocator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bitmap_page_allocator
// First-fit page allocator over a used-page bitmap held in one memory.
// ----------------------------------------------------------------------------
// A command is taken when start is high and busy is low; each command gives
// exactly one result, shown for one cycle with o_done, and the receiver cannot
// stall it. After reset the block sweeps the bitmap to all used, one word per
// cycle, with busy high. The bitmap words are examined one bit per cycle
// through a shift register, and each word visited takes a read, a load and 32
// bit steps, plus a write-back when the word is changed. An allocate scans
// from page 0 up to the end of the first fitting run (at most all words) and
// then rewrites the words the run covers; a free rewrites only the words its
// run covers. A zero count, or a free that starts past the last page, finishes
// straight from idle without a memory access.
// ----------------------------------------------------------------------------
module bitmap_page_allocator #(
    parameter int unsigned TOTAL_PAGES = 4096
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            start,
    output logic                            busy,
    input  logic                            i_command,
    input  logic [bpa_pkg::INDEX_W-1:0]     i_page_index,
    input  logic [bpa_pkg::COUNT_W-1:0]     i_page_count,
    output logic                            o_done,
    output logic                            o_status,
    output logic [bpa_pkg::INDEX_W-1:0]     o_first_page
);

    localparam int unsigned MAP_WORDS = (TOTAL_PAGES + 31) / 32;
    localparam int unsigned AW        = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
    localparam int unsigned PGW_RAW   = $clog2(TOTAL_PAGES) + 1;
    localparam int unsigned PGW       = (PGW_RAW > 13) ? PGW_RAW : 13;
    localparam int unsigned BW        = bpa_pkg::BIT_SEL_W;
    localparam int unsigned WB        = bpa_pkg::WORD_BITS;

    localparam logic [PGW-1:0] PG_TOTAL   = PGW'(TOTAL_PAGES);
    localparam logic [PGW-1:0] PG_LAST    = PGW'(TOTAL_PAGES - 1);
    localparam logic [AW-1:0]  ADDR_LAST  = AW'(MAP_WORDS - 1);
    localparam logic [BW-1:0]  BIT_LAST   = BW'(WB - 1);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_RD,
        S_LD,
        S_SCAN,
        S_MOD,
        S_WB
    } t_state;

    logic [WB-1:0]  r_mem [MAP_WORDS];
    logic [WB-1:0]  r_rd_data;

    t_state         r_state,  n_state;
    logic [AW-1:0]  r_addr,   n_addr;
    logic [WB-1:0]  r_sr,     n_sr;
    logic [BW-1:0]  r_bit,    n_bit;
    logic [PGW-1:0] r_page,   n_page;
    logic [PGW-1:0] r_run,    n_run;
    logic [PGW-1:0] r_count,  n_count;
    logic [PGW-1:0] r_start,  n_start;
    logic [PGW-1:0] r_remain, n_remain;
    logic           r_mode,   n_mode;
    logic           r_done,   n_done;
    logic           r_status, n_status;
    logic [bpa_pkg::INDEX_W-1:0] r_first, n_first;

    logic           mem_we;
    logic [WB-1:0]  mem_wdata;
    logic [PGW-1:0] idx_ext;
    logic [PGW-1:0] cnt_ext;
    logic [PGW-1:0] run_inc;
    logic [PGW-1:0] found_start;
    logic           hit;
    logic           new_bit;

    assign idx_ext     = PGW'(i_page_index);
    assign cnt_ext     = PGW'(i_page_count);
    assign run_inc     = r_run + PGW'(1);
    assign found_start = r_page + PGW'(1) - r_count;
    assign hit         = (r_page >= r_start) && (r_remain != '0) && (r_page < PG_TOTAL);
    assign new_bit     = hit ? r_mode : r_sr[0];

    assign mem_we    = (r_state == S_CLEAR) || (r_state == S_WB);
    assign mem_wdata = (r_state == S_CLEAR) ? '1 : r_sr;

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[r_addr] <= mem_wdata;
        end
        r_rd_data <= r_mem[r_addr];
    end

    always_comb begin
        n_state  = r_state;
        n_addr   = r_addr;
        n_sr     = r_sr;
        n_bit    = r_bit;
        n_page   = r_page;
        n_run    = r_run;
        n_count  = r_count;
        n_start  = r_start;
        n_remain = r_remain;
        n_mode   = r_mode;
        n_done   = 1'b0;
        n_status = r_status;
        n_first  = r_first;

        case (r_state)
            S_CLEAR: begin
                if (r_addr == ADDR_LAST) begin
                    n_addr  = '0;
                    n_state = S_IDLE;
                end else begin
                    n_addr = r_addr + AW'(1);
                end
            end
            S_IDLE: begin
                if (start) begin
                    n_first  = '0;
                    n_status = bpa_pkg::STATUS_DONE;
                    n_bit    = '0;
                    if (i_command == bpa_pkg::CMD_FREE) begin
                        if ((cnt_ext == '0) || (idx_ext >= PG_TOTAL)) begin
                            n_done = 1'b1;
                        end else begin
                            n_mode   = 1'b0;
                            n_start  = idx_ext;
                            n_remain = cnt_ext;
                            n_page   = {idx_ext[PGW-1:BW], {BW{1'b0}}};
                            n_addr   = idx_ext[BW +: AW];
                            n_state  = S_RD;
                        end
                    end else begin
                        if (cnt_ext == '0) begin
                            n_status = bpa_pkg::STATUS_NO_SPACE;
                            n_done   = 1'b1;
                        end else begin
                            n_count = cnt_ext;
                            n_run   = '0;
                            n_page  = '0;
                            n_addr  = '0;
                            n_state = S_RD;
                        end
                    end
                end
            end
            S_RD: begin
                n_state = S_LD;
            end
            S_LD: begin
                n_sr    = r_rd_data;
                n_bit   = '0;
                n_state = (r_mode || (r_remain != '0)) ? S_MOD : S_SCAN;
            end
            S_SCAN: begin
                n_sr   = r_sr >> 1;
                n_bit  = r_bit + BW'(1);
                n_page = r_page + PGW'(1);
                n_run  = r_sr[0] ? '0 : run_inc;
                if (!r_sr[0] && (run_inc == r_count)) begin
                    n_first  = found_start[bpa_pkg::INDEX_W-1:0];
                    n_mode   = 1'b1;
                    n_start  = found_start;
                    n_remain = r_count;
                    n_page   = {found_start[PGW-1:BW], {BW{1'b0}}};
                    n_addr   = found_start[BW +: AW];
                    n_state  = S_RD;
                end else if (r_page == PG_LAST) begin
                    n_status = bpa_pkg::STATUS_NO_SPACE;
                    n_done   = 1'b1;
                    n_state  = S_IDLE;
                end else if (r_bit == BIT_LAST) begin
                    n_addr  = r_addr + AW'(1);
                    n_state = S_RD;
                end
            end
            S_MOD: begin
                n_sr   = {new_bit, r_sr[WB-1:1]};
                n_bit  = r_bit + BW'(1);
                n_page = r_page + PGW'(1);
                if (hit) begin
                    n_remain = r_remain - PGW'(1);
                end
                if (r_bit == BIT_LAST) begin
                    n_state = S_WB;
                end
            end
            S_WB: begin
                if ((r_remain == '0) || (r_page >= PG_TOTAL) || (r_addr == ADDR_LAST)) begin
                    n_remain = '0;
                    n_mode   = 1'b0;
                    n_done   = 1'b1;
                    n_state  = S_IDLE;
                end else begin
                    n_addr  = r_addr + AW'(1);
                    n_state = S_RD;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLEAR;
            r_addr   <= '0;
            r_remain <= '0;
            r_mode   <= 1'b0;
            r_done   <= 1'b0;
            r_status <= bpa_pkg::STATUS_DONE;
            r_first  <= '0;
        end else begin
            r_state  <= n_state;
            r_addr   <= n_addr;
            r_remain <= n_remain;
            r_mode   <= n_mode;
            r_done   <= n_done;
            r_status <= n_status;
            r_first  <= n_first;
        end
        r_sr    <= n_sr;
        r_bit   <= n_bit;
        r_page  <= n_page;
        r_run   <= n_run;
        r_count <= n_count;
        r_start <= n_start;
    end

    assign busy         = (r_state != S_IDLE);
    assign o_done       = r_done;
    assign o_status     = r_status;
    assign o_first_page = r_first;

endmodule

### bench/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the first-fit bitmap page allocator.
// ----------------------------------------------------------------------------
// A queue of page commands is filled up front: a directed run over the empty
// and full map, zero counts, frees past the end and double frees, then random
// traffic kept mostly in the low thousand pages so that scans stay short. A
// clocked driver issues the commands through start/busy with random gaps
// outside a quiet stretch; a shadow bitmap predicts every result, and a
// clocked monitor checks each o_done transfer against the oldest prediction.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int unsigned TOTAL_PAGES  = 4096;
    localparam int unsigned STALL_LIMIT  = 50000;
    localparam int unsigned TAIL_CYCLES  = 500;
    localparam int unsigned RANDOM_CMDS  = 432;
    localparam int unsigned QUIET_FIRST  = 150;
    localparam int unsigned QUIET_LAST   = 260;
    localparam int unsigned WORK_PAGES   = 1024;

    typedef struct packed {
        logic                        cmd;
        logic [bpa_pkg::INDEX_W-1:0] index;
        logic [bpa_pkg::COUNT_W-1:0] count;
        logic                        drain;
    } t_page_cmd;

    typedef struct packed {
        logic                        status;
        logic [bpa_pkg::INDEX_W-1:0] first_page;
    } t_page_result;

    logic                        i_clk        = 1'b0;
    logic                        i_rst_n      = 1'b0;
    logic                        start        = 1'b0;
    logic                        busy;
    logic                        i_command    = bpa_pkg::CMD_ALLOC;
    logic [bpa_pkg::INDEX_W-1:0] i_page_index = '0;
    logic [bpa_pkg::COUNT_W-1:0] i_page_count = '0;
    logic                        o_done;
    logic                        o_status;
    logic [bpa_pkg::INDEX_W-1:0] o_first_page;

    t_page_cmd          pending_cmds[$];
    t_page_result       awaited_results[$];
    t_page_cmd          issued_cmd   = '0;
    logic [TOTAL_PAGES-1:0] shadow_used_map = '1;
    int unsigned        sent_cnt     = 0;
    int unsigned        total_cmds   = 0;
    int unsigned        mismatch_cnt = 0;
    int unsigned        stall_cycles = 0;

    always #1 i_clk = ~i_clk;

    bitmap_page_allocator #(
        .TOTAL_PAGES (TOTAL_PAGES)
    ) u_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .busy         (busy),
        .i_command    (i_command),
        .i_page_index (i_page_index),
        .i_page_count (i_page_count),
        .o_done       (o_done),
        .o_status     (o_status),
        .o_first_page (o_first_page)
    );

    function automatic t_page_result apply_page_cmd(input t_page_cmd c);
        t_page_result res;
        int unsigned  run_len;
        int unsigned  run_end;
        int unsigned  base;
        int unsigned  p;
        int unsigned  q;
        res.status     = bpa_pkg::STATUS_DONE;
        res.first_page = '0;
        if (c.cmd == bpa_pkg::CMD_FREE) begin
            run_end = c.index + c.count;
            for (p = c.index; p < run_end && p < TOTAL_PAGES; p++)
                shadow_used_map[p] = 1'b0;
        end else begin
            res.status = bpa_pkg::STATUS_NO_SPACE;
            run_len    = 0;
            if (c.count != 0) begin
                for (p = 0; p < TOTAL_PAGES && res.status == bpa_pkg::STATUS_NO_SPACE;
                     p++) begin
                    if (shadow_used_map[p]) begin
                        run_len = 0;
                    end else begin
                        run_len++;
                        if (run_len == c.count) begin
                            base = p + 1 - c.count;
                            for (q = base; q <= p; q++)
                                shadow_used_map[q] = 1'b1;
                            res.status     = bpa_pkg::STATUS_DONE;
                            res.first_page = base[bpa_pkg::INDEX_W-1:0];
                        end
                    end
                end
            end
        end
        return res;
    endfunction

    task automatic queue_cmd(input logic cmd, input int unsigned index,
                             input int unsigned count, input logic drain);
        t_page_cmd c;
        c.cmd   = cmd;
        c.index = index[bpa_pkg::INDEX_W-1:0];
        c.count = count[bpa_pkg::COUNT_W-1:0];
        c.drain = drain;
        pending_cmds.push_back(c);
    endtask

    task automatic report_mismatch(input string msg);
        $display("[%0t] MISMATCH: %s", $time, msg);
        mismatch_cnt++;
    endtask

    // driver: hold the command while busy, otherwise issue the next one
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            start <= 1'b0;
        end else begin
            if (start && !busy) begin
                awaited_results.push_back(apply_page_cmd(issued_cmd));
                sent_cnt <= sent_cnt + 1;
            end
            if (start && busy) begin
            end else if (pending_cmds.size() != 0
                         && !(pending_cmds[0].drain && awaited_results.size() != 0)
                         && ((sent_cnt >= QUIET_FIRST && sent_cnt < QUIET_LAST)
                             || $urandom_range(0, 99) >= 15)) begin
                issued_cmd   <= pending_cmds[0];
                i_command    <= pending_cmds[0].cmd;
                i_page_index <= pending_cmds[0].index;
                i_page_count <= pending_cmds[0].count;
                start        <= 1'b1;
                void'(pending_cmds.pop_front());
            end else begin
                start <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin : monitor
        t_page_result want;
        if (i_rst_n && o_done) begin
            if (awaited_results.size() == 0) begin
                report_mismatch($sformatf("result status %0b page %0d with none awaited",
                                          o_status, o_first_page));
            end else begin
                want = awaited_results.pop_front();
                if (o_status !== want.status)
                    report_mismatch($sformatf("status %b, want %b", o_status, want.status));
                if (o_first_page !== want.first_page)
                    report_mismatch($sformatf("first_page %0d, want %0d",
                                              o_first_page, want.first_page));
            end
        end
    end

    always @(posedge i_clk) begin
        if ((start && !busy) || o_done)
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT) begin
            $display("[%0t] no transfer for %0d cycles", $time, STALL_LIMIT);
            $display("** bitmap_page_allocator: FAILED **");
            $finish;
        end
    end

    initial begin
        int unsigned n;
        int unsigned pick;

        queue_cmd(bpa_pkg::CMD_ALLOC, 0,    1,    1'b0);
        queue_cmd(bpa_pkg::CMD_ALLOC, 0,    0,    1'b0);
        queue_cmd(bpa_pkg::CMD_FREE,  0,    0,    1'b0);
        queue_cmd(bpa_pkg::CMD_FREE,  4095, 4096, 1'b0);
        queue_cmd(bpa_pkg::CMD_ALLOC, 2730, 1,    1'b0);
        queue_cmd(bpa_pkg::CMD_FREE,  0,    4096, 1'b0);
        queue_cmd(bpa_pkg::CMD_ALLOC, 1365, 4096, 1'b0);
        queue_cmd(bpa_pkg::CMD_ALLOC, 0,    1,    1'b0);
        queue_cmd(bpa_pkg::CMD_FREE,  0,    64,   1'b0);
        queue_cmd(bpa_pkg::CMD_ALLOC, 4095, 1,    1'b0);
        queue_cmd(bpa_pkg::CMD_ALLOC, 0,    63,   1'b0);
        queue_cmd(bpa_pkg::CMD_FREE,  100,  10,   1'b0);
        queue_cmd(bpa_pkg::CMD_FREE,  100,  10,   1'b0);
        queue_cmd(bpa_pkg::CMD_ALLOC, 0,    11,   1'b0);
        queue_cmd(bpa_pkg::CMD_ALLOC, 0,    10,   1'b0);
        queue_cmd(bpa_pkg::CMD_FREE,  2048, 4096, 1'b0);
        queue_cmd(bpa_pkg::CMD_ALLOC, 0,    2048, 1'b0);
        queue_cmd(bpa_pkg::CMD_FREE,  0,    WORK_PAGES, 1'b0);

        // keep most traffic inside the working pages so scans stay short
        for (n = 0; n < RANDOM_CMDS; n++) begin
            pick = $urandom_range(0, 99);
            if (pick < 45)
                queue_cmd(bpa_pkg::CMD_ALLOC, $urandom_range(0, 4095),
                          ($urandom_range(0, 99) < 85) ? $urandom_range(1, 16)
                                                       : $urandom_range(17, 128),
                          n == 0 || n == 200);
            else if (pick < 88)
                queue_cmd(bpa_pkg::CMD_FREE, $urandom_range(0, WORK_PAGES - 1),
                          $urandom_range(1, 64), n == 0 || n == 200);
            else if (pick < 93)
                queue_cmd(bpa_pkg::CMD_FREE, $urandom_range(0, 4095),
                          $urandom_range(0, 4096), n == 0 || n == 200);
            else if (pick < 97)
                queue_cmd(bpa_pkg::CMD_ALLOC, $urandom_range(0, 4095),
                          $urandom_range(0, 4096), n == 0 || n == 200);
            else
                queue_cmd(1'($urandom_range(0, 1)), $urandom_range(0, 4095), 0,
                          n == 0 || n == 200);
        end
        total_cmds = pending_cmds.size();

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (sent_cnt != total_cmds || awaited_results.size() != 0)
            @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);

        if (mismatch_cnt == 0)
            $display("** bitmap_page_allocator: PASSED **");
        else
            $display("** bitmap_page_allocator: FAILED **");
        $finish;
    end

endmodule
